### rtl/core/atrp_pkg.sv
package atrp_pkg;

    localparam int ANGLE_FRAC_BITS = 7;
    localparam int CORDIC_STEPS    = 16;

    localparam int ACC_FRAC   = 20;
    localparam int ACC_W      = 30;
    localparam int CD_W       = 36;
    localparam int RT_W       = 32;
    localparam int SQRT_STEPS = RT_W;
    localparam int TAB_LEN    = 24;
    localparam int OUT_SH     = ACC_FRAC - ANGLE_FRAC_BITS;

    // stage numbering along the pipe
    localparam int ST_SQ    = 0;
    localparam int ST_SUM   = 1;
    localparam int ST_RT0   = 2;
    localparam int ST_PREP  = ST_RT0 + SQRT_STEPS;
    localparam int ST_CD0   = ST_PREP + 1;
    localparam int ST_OUT   = ST_CD0 + CORDIC_STEPS;
    localparam int N_STAGES = ST_OUT + 1;

    localparam logic signed [ACC_W-1:0] DEG90  = 30'sd94371840;
    localparam logic signed [ACC_W-1:0] DEG180 = 30'sd188743680;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (OUT_SH - 1);
    localparam logic signed [ACC_W-1:0] LIM_ROLL  = ACC_W'(180) << ANGLE_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] LIM_PITCH = ACC_W'(90) << ANGLE_FRAC_BITS;

    // atan(2^-i) in degrees, 20 fraction bits
    localparam logic signed [ACC_W-1:0] ATAN_TAB [0:TAB_LEN-1] = '{
        30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
        30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
        30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
        30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
        30'sd917,      30'sd458,      30'sd229,      30'sd115,
        30'sd57,       30'sd29,       30'sd14,       30'sd7
    };

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [30:0]        yy;
        logic [30:0]        zz;
    } t_sq;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [31:0]        s;
    } t_sum;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [31:0]        bits;
        logic [33:0]        rem;
        logic [RT_W-1:0]    q;
    } t_rt;

    typedef struct packed {
        logic signed [CD_W-1:0]  px;
        logic signed [CD_W-1:0]  py;
        logic signed [ACC_W-1:0] ang;
        logic                    fixd;
    } t_atan;

    typedef struct packed {
        t_atan roll;
        t_atan pitch;
    } t_cd;

    // one result bit of the square root per call
    function automatic t_rt rt_step(t_rt a);
        t_rt        b;
        logic [35:0] w;
        logic [35:0] trial;
        b      = a;
        w      = {a.rem, a.bits[31:30]};
        trial  = {2'b00, a.q, 2'b01};
        b.bits = {a.bits[29:0], 2'b00};
        if (w >= trial) begin
            b.rem = 34'(w - trial);
            b.q   = {a.q[RT_W-2:0], 1'b1};
        end else begin
            b.rem = w[33:0];
            b.q   = {a.q[RT_W-2:0], 1'b0};
        end
        return b;
    endfunction

    // quadrant fold and the exact axis cases
    function automatic t_atan atan_prep(logic signed [CD_W-1:0] num,
                                        logic signed [CD_W-1:0] den);
        t_atan a;
        a.px   = den;
        a.py   = num;
        a.ang  = '0;
        a.fixd = 1'b0;
        if (num == '0) begin
            a.fixd = 1'b1;
            a.ang  = den[CD_W-1] ? DEG180 : '0;
        end else if (den == '0) begin
            a.fixd = 1'b1;
            a.ang  = num[CD_W-1] ? -DEG90 : DEG90;
        end else if (den[CD_W-1]) begin
            a.px  = -den;
            a.py  = -num;
            a.ang = num[CD_W-1] ? -DEG180 : DEG180;
        end
        return a;
    endfunction

    function automatic t_atan cd_step(t_atan a, int i);
        t_atan b;
        logic signed [CD_W-1:0] sx;
        logic signed [CD_W-1:0] sy;
        b  = a;
        sx = a.py >>> i;
        sy = a.px >>> i;
        if (!a.fixd) begin
            if (!a.py[CD_W-1]) begin
                b.px  = a.px + sx;
                b.py  = a.py - sy;
                b.ang = a.ang + ATAN_TAB[i];
            end else begin
                b.px  = a.px - sx;
                b.py  = a.py + sy;
                b.ang = a.ang - ATAN_TAB[i];
            end
        end
        return b;
    endfunction

    // round half up to the output grid, then clamp
    function automatic logic signed [ACC_W-1:0] to_out(logic signed [ACC_W-1:0] acc,
                                                       logic signed [ACC_W-1:0] lim);
        logic signed [ACC_W-1:0] r;
        r = (acc + RND_HALF) >>> OUT_SH;
        if (r > lim) begin
            r = lim;
        end
        if (r < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

endpackage

### rtl/core/accel_tilt_roll_pitch.sv
// channel   direction  handshake            word
// sample    in         i_valid / o_ready    i_accel_x, i_accel_y, i_accel_z
// angles    out        o_valid / i_ready    o_roll_angle, o_pitch_angle
//
// one sample a cycle while the result is taken or some stage is empty
// the pipe length is set by the bit-serial square root (32 stages) and the CORDIC stages
// each stage holds its word until the next one frees, so empty stages close up
// under a stall and the input keeps being taken while the result waits, until every stage is full
// reset clears the valid bits only
module accel_tilt_roll_pitch (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_roll_angle,
    output logic signed [14:0] o_pitch_angle
);

    localparam int NS = atrp_pkg::N_STAGES;
    localparam int CW = atrp_pkg::CD_W;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] adv;

    atrp_pkg::t_sq  r_sq;
    atrp_pkg::t_sum r_sum;
    atrp_pkg::t_rt  r_rt [atrp_pkg::SQRT_STEPS];
    atrp_pkg::t_cd  r_prep;
    atrp_pkg::t_cd  r_cd [atrp_pkg::CORDIC_STEPS];
    logic signed [15:0] r_roll;
    logic signed [14:0] r_pitch;

    logic signed [31:0] sq_y;
    logic signed [31:0] sq_z;
    atrp_pkg::t_rt      rt_init;
    logic [16:0]        neg_x;
    atrp_pkg::t_cd      prep_in;
    atrp_pkg::t_atan    fin_roll;
    atrp_pkg::t_atan    fin_pitch;
    logic signed [atrp_pkg::ACC_W-1:0] out_roll;
    logic signed [atrp_pkg::ACC_W-1:0] out_pitch;

    // a stage moves on when empty or when the one after it moves
    always_comb begin
        adv[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
        n_vld = r_vld;
        if (adv[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < NS; k++) begin
            if (adv[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_vld[NS-1];

    // squares
    assign sq_y = i_accel_y * i_accel_y;
    assign sq_z = i_accel_z * i_accel_z;

    always_ff @(posedge i_clk) begin
        if (adv[atrp_pkg::ST_SQ]) begin
            r_sq.x  <= i_accel_x;
            r_sq.y  <= i_accel_y;
            r_sq.z  <= i_accel_z;
            r_sq.yy <= sq_y[30:0];
            r_sq.zz <= sq_z[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[atrp_pkg::ST_SUM]) begin
            r_sum.x <= r_sq.x;
            r_sum.y <= r_sq.y;
            r_sum.z <= r_sq.z;
            r_sum.s <= {1'b0, r_sq.yy} + {1'b0, r_sq.zz};
        end
    end

    // square root of s * 2^32, two radicand bits per stage
    always_comb begin
        rt_init.x    = r_sum.x;
        rt_init.y    = r_sum.y;
        rt_init.z    = r_sum.z;
        rt_init.bits = r_sum.s;
        rt_init.rem  = '0;
        rt_init.q    = '0;
    end

    for (genvar j = 0; j < atrp_pkg::SQRT_STEPS; j++) begin : g_rt
        atrp_pkg::t_rt w_in;
        if (j == 0) begin : g_first
            assign w_in = rt_init;
        end else begin : g_next
            assign w_in = r_rt[j-1];
        end
        always_ff @(posedge i_clk) begin
            if (adv[atrp_pkg::ST_RT0 + j]) begin
                r_rt[j] <= atrp_pkg::rt_step(w_in);
            end
        end
    end

    // roll = atan2(y, z), pitch = atan2(-x, r), all scaled by 2^16
    always_comb begin
        neg_x = -{r_rt[atrp_pkg::SQRT_STEPS-1].x[15], r_rt[atrp_pkg::SQRT_STEPS-1].x};
        prep_in.roll = atrp_pkg::atan_prep(
            {{(CW-32){r_rt[atrp_pkg::SQRT_STEPS-1].y[15]}},
             r_rt[atrp_pkg::SQRT_STEPS-1].y, 16'h0000},
            {{(CW-32){r_rt[atrp_pkg::SQRT_STEPS-1].z[15]}},
             r_rt[atrp_pkg::SQRT_STEPS-1].z, 16'h0000});
        prep_in.pitch = atrp_pkg::atan_prep(
            {{(CW-33){neg_x[16]}}, neg_x, 16'h0000},
            {{(CW-atrp_pkg::RT_W){1'b0}}, r_rt[atrp_pkg::SQRT_STEPS-1].q});
    end

    always_ff @(posedge i_clk) begin
        if (adv[atrp_pkg::ST_PREP]) begin
            r_prep <= prep_in;
        end
    end

    for (genvar i = 0; i < atrp_pkg::CORDIC_STEPS; i++) begin : g_cd
        atrp_pkg::t_cd w_in;
        if (i == 0) begin : g_first
            assign w_in = r_prep;
        end else begin : g_next
            assign w_in = r_cd[i-1];
        end
        always_ff @(posedge i_clk) begin
            if (adv[atrp_pkg::ST_CD0 + i]) begin
                r_cd[i].roll  <= atrp_pkg::cd_step(w_in.roll, i);
                r_cd[i].pitch <= atrp_pkg::cd_step(w_in.pitch, i);
            end
        end
    end

    always_comb begin
        fin_roll  = r_cd[atrp_pkg::CORDIC_STEPS-1].roll;
        fin_pitch = r_cd[atrp_pkg::CORDIC_STEPS-1].pitch;
        out_roll  = atrp_pkg::to_out(fin_roll.ang, atrp_pkg::LIM_ROLL);
        out_pitch = atrp_pkg::to_out(fin_pitch.ang, atrp_pkg::LIM_PITCH);
    end

    always_ff @(posedge i_clk) begin
        if (adv[atrp_pkg::ST_OUT]) begin
            r_roll  <= out_roll[15:0];
            r_pitch <= out_pitch[14:0];
        end
    end

    assign o_roll_angle  = r_roll;
    assign o_pitch_angle = r_pitch;

endmodule
